### sv/i8dq_pkg.sv
// ----------------------------------------------------------------------------
// i8dq_pkg
// Shared types and constants for the int8 dot product requantize unit.
// ----------------------------------------------------------------------------
package i8dq_pkg;

  localparam int unsigned LANES     = 4;
  localparam int unsigned LANE_W    = 2;
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned ACC_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_ZERO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_ZERO  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_ZERO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_MULT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_SHIFT = 3'd4;

  localparam logic signed [31:0] SCALE_MULT_RESET  = 32'sd1073741824;
  localparam logic signed [5:0]  SCALE_SHIFT_RESET = -6'sd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_MUL,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic              load;
    logic              mac;
    logic [LANE_W-1:0] lane;
    logic              mul;
    logic              fin;
  } i8dq_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] n_lanes;
    logic             last;
    logic             out_busy;
  } i8dq_sts_t;

endpackage

### sv/i8dq_ctrl.sv
// ----------------------------------------------------------------------------
// i8dq_ctrl
// Sequencer: takes a word, steps the lanes through the shared multiplier,
// then runs the scale multiply and the rounding stage on the last word.
// ----------------------------------------------------------------------------
module i8dq_ctrl import i8dq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  i8dq_sts_t sts,
  output i8dq_cmd_t cmd
);

  state_t            state_r, state_nxt;
  logic [LANE_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  cnt_inc;

  assign cnt_inc = {1'b0, cnt_r} + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.lane  = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        cmd.mac = ({1'b0, cnt_r} < sts.n_lanes);
        if (cnt_inc >= sts.n_lanes) begin
          state_nxt = sts.last ? ST_MUL : ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + LANE_W'(1);
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!sts.out_busy) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### sv/i8dq_datapath.sv
// ----------------------------------------------------------------------------
// i8dq_datapath
// Config registers, word holding register, lane multiply-accumulate,
// scale multiply, rounding shift, output zero point and int8 saturation.
// ----------------------------------------------------------------------------
module i8dq_datapath import i8dq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DAT_W-1:0]  cfg_wdata,
  input  logic signed [7:0]     in_weight_lane0,
  input  logic signed [7:0]     in_weight_lane1,
  input  logic signed [7:0]     in_weight_lane2,
  input  logic signed [7:0]     in_weight_lane3,
  input  logic signed [7:0]     in_act_lane0,
  input  logic signed [7:0]     in_act_lane1,
  input  logic signed [7:0]     in_act_lane2,
  input  logic signed [7:0]     in_act_lane3,
  input  logic [2:0]            in_lanes_valid,
  input  logic                  in_last_step,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [7:0]     out_value,
  input  i8dq_cmd_t             cmd,
  output i8dq_sts_t             sts
);

  logic signed [7:0]  weight_zero_r, input_zero_r, output_zero_r;
  logic signed [31:0] scale_mult_r;
  logic signed [5:0]  scale_shift_r;

  logic signed [7:0]  w_r [LANES];
  logic signed [7:0]  a_r [LANES];
  logic [CNT_W-1:0]   n_r;
  logic               last_r;

  logic [ACC_W-1:0]   acc_r;
  logic signed [63:0] prod_r;
  logic               out_valid_r;
  logic signed [7:0]  out_value_r;

  logic signed [8:0]  w_d, a_d;
  logic signed [17:0] lane_prod;
  logic [CNT_W-1:0]   n_clamp;
  logic [4:0]         shamt;
  logic signed [32:0] hi_ext, rnd, hi_rnd, shifted;
  logic signed [33:0] biased;
  logic signed [7:0]  sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_zero_r <= '0;
      input_zero_r  <= '0;
      output_zero_r <= '0;
      scale_mult_r  <= SCALE_MULT_RESET;
      scale_shift_r <= SCALE_SHIFT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WEIGHT_ZERO: weight_zero_r <= cfg_wdata[7:0];
        CFG_INPUT_ZERO:  input_zero_r  <= cfg_wdata[7:0];
        CFG_OUTPUT_ZERO: output_zero_r <= cfg_wdata[7:0];
        CFG_SCALE_MULT:  scale_mult_r  <= cfg_wdata[31:0];
        CFG_SCALE_SHIFT: scale_shift_r <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  assign n_clamp = (in_lanes_valid > CNT_W'(LANES)) ? CNT_W'(LANES) : in_lanes_valid;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_r[0] <= in_weight_lane0;
      w_r[1] <= in_weight_lane1;
      w_r[2] <= in_weight_lane2;
      w_r[3] <= in_weight_lane3;
      a_r[0] <= in_act_lane0;
      a_r[1] <= in_act_lane1;
      a_r[2] <= in_act_lane2;
      a_r[3] <= in_act_lane3;
      n_r    <= n_clamp;
      last_r <= in_last_step;
    end
  end

  // one lane through the shared multiplier
  always_comb begin
    w_d       = $signed({w_r[cmd.lane][7], w_r[cmd.lane]})
              - $signed({weight_zero_r[7], weight_zero_r});
    a_d       = $signed({a_r[cmd.lane][7], a_r[cmd.lane]})
              - $signed({input_zero_r[7], input_zero_r});
    lane_prod = w_d * a_d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (cmd.mul) begin
      acc_r <= '0;
    end else if (cmd.mac) begin
      acc_r <= acc_r + ACC_W'(32'(lane_prod));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= $signed(acc_r) * scale_mult_r;
    end
  end

  // rounding right shift by ~scale_shift, modulo 32
  always_comb begin
    shamt   = ~scale_shift_r[4:0];
    hi_ext  = $signed({prod_r[63], prod_r[63:32]});
    rnd     = (shamt == 5'd0) ? 33'sd0 : $signed(33'd1 << (shamt - 5'd1));
    hi_rnd  = hi_ext + rnd;
    shifted = hi_rnd >>> shamt;
    biased  = $signed({shifted[32], shifted}) + 34'(output_zero_r);
    if (biased > 34'sd127) begin
      sat = 8'sd127;
    end else if (biased < -34'sd128) begin
      sat = -8'sd128;
    end else begin
      sat = biased[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_value_r <= sat;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign sts.n_lanes  = n_r;
  assign sts.last     = last_r;
  assign sts.out_busy = out_valid_r && !out_ready;

endmodule

### sv/int8_dot_requantize_unit.sv
// ----------------------------------------------------------------------------
// int8_dot_requantize_unit
// Streaming int8 dot product with requantization to a saturated int8 result.
//
// Input channel: in_valid/in_ready with up to four weight/activation lanes,
// in_lanes_valid (clamped to four) and in_last_step. Output channel:
// out_valid/out_ready carrying out_value, one word per word marked last.
// Config: cfg_we/cfg_index/cfg_wdata. The user must write the config only
// while the unit is idle; the unit itself does not enforce this.
//
// The valid lanes of a word pass one at a time through the single shared
// lane multiplier; no new word is accepted until the current one is done. A
// last word then goes through the 32x32 scale multiply and the rounding and
// saturation stage. The output register lets the next word be accepted while
// a result waits; a stalled receiver holds only the rounding step of the
// following result. Reset clears the accumulator, the output valid and the
// config registers (multiplier to 2^30, shift to -1, zero points to 0).
// ----------------------------------------------------------------------------
module int8_dot_requantize_unit import i8dq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DAT_W-1:0]  cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [7:0]     in_weight_lane0,
  input  logic signed [7:0]     in_weight_lane1,
  input  logic signed [7:0]     in_weight_lane2,
  input  logic signed [7:0]     in_weight_lane3,
  input  logic signed [7:0]     in_act_lane0,
  input  logic signed [7:0]     in_act_lane1,
  input  logic signed [7:0]     in_act_lane2,
  input  logic signed [7:0]     in_act_lane3,
  input  logic [2:0]            in_lanes_valid,
  input  logic                  in_last_step,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [7:0]     out_value
);

  i8dq_cmd_t cmd;
  i8dq_sts_t sts;

  i8dq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  i8dq_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_weight_lane0 (in_weight_lane0),
    .in_weight_lane1 (in_weight_lane1),
    .in_weight_lane2 (in_weight_lane2),
    .in_weight_lane3 (in_weight_lane3),
    .in_act_lane0    (in_act_lane0),
    .in_act_lane1    (in_act_lane1),
    .in_act_lane2    (in_act_lane2),
    .in_act_lane3    (in_act_lane3),
    .in_lanes_valid  (in_lanes_valid),
    .in_last_step    (in_last_step),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_value       (out_value),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule
